FILE: rtl/core/sorted_index_set_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted index set
// Concurrent checks clocked on clk_i, held off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_INDEX_SET_ASSERT_SVH
`define SORTED_INDEX_SET_ASSERT_SVH

// Same-cycle implication.
`define SIS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted_index_set check failed");

// Next-cycle implication.
`define SIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_index_set check failed");

`endif

FILE: rtl/core/sis_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sis_pkg
// Shared constants for the sorted index set: opcodes, field widths and the default capacity.
// ---------------------------------------------------------------------------
package sis_pkg;

  localparam int unsigned KEY_W            = 32;
  localparam int unsigned OPCODE_W         = 2;
  localparam int unsigned CNT_OUT_W        = 9;
  localparam int unsigned DEFAULT_CAPACITY = 256;

  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_MARK   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_UNMARK = 2'd2;

endpackage

FILE: rtl/core/sorted_index_set.sv
`timescale 1ns / 1ps
`include "sorted_index_set_assert.svh"
// ---------------------------------------------------------------------------
// sorted_index_set
// Ascending, duplicate-free set of 32-bit frame indices held in one RAM,
// with query, mark (sorted insert) and unmark (remove) operations.
// ---------------------------------------------------------------------------
// Timing: one beat is handled at a time. Each probe of the binary search
// over the RAM puts out the address, then compares the registered read data,
// and a decision step ends the search. An insert or remove then moves the
// entries behind the found slot through the single RAM port pair, one entry
// per cycle and then a flush step; an insert then writes the new key.
// A query costs only the search. The input takes a new beat while a finished
// result still waits on the output. No clearing pass is needed after reset:
// entries beyond the count are never read.
// ---------------------------------------------------------------------------
module sorted_index_set
  import sis_pkg::*;
#(
  parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OPCODE_W-1:0]  opcode_i,
  input  logic [KEY_W-1:0]     frame_index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 was_present_o,
  output logic                 dropped_o,
  output logic [CNT_OUT_W-1:0] entry_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_CMP    = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_FLUSH  = 3'd4;
  localparam logic [2:0] ST_KEYWR  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]          state_q;
  logic [CW-1:0]       count_q;
  logic [OPCODE_W-1:0] op_q;
  logic [KEY_W-1:0]    key_q;
  logic [CW-1:0]       lo_q, hi_q;
  logic                hit_q;
  logic                res_drop_q;
  logic                ins_q;
  logic [CW-1:0]       src_q, last_q;
  logic                wr_pend_q;
  logic [CW-1:0]       wr_addr_q;

  logic                out_valid_q;
  logic                was_present_q;
  logic                dropped_q;
  logic [CNT_OUT_W-1:0] entry_count_q;

  logic [CW-1:0]       mid;
  logic [CW-1:0]       raddr_c;
  logic [CW-1:0]       waddr_c;
  logic [KEY_W-1:0]    wdata_c;
  logic                mem_we;
  logic [KEY_W-1:0]    rd_data;
  logic                out_free;

  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign was_present_o = was_present_q;
  assign dropped_o     = dropped_q;
  assign entry_count_o = entry_count_q;

  // RAM port steering
  always_comb begin
    mem_we  = 1'b0;
    waddr_c = wr_addr_q;
    wdata_c = rd_data;
    raddr_c = src_q;
    unique case (state_q)
      ST_SEARCH: raddr_c = mid;
      ST_SHIFT:  mem_we  = wr_pend_q;
      ST_FLUSH:  mem_we  = 1'b1;
      ST_KEYWR: begin
        mem_we  = 1'b1;
        waddr_c = lo_q;
        wdata_c = key_q;
      end
      default: ;
    endcase
  end

  sis_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr_c[AW-1:0]),
    .wdata_i (wdata_c),
    .raddr_i (raddr_c[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      op_q       <= OP_QUERY;
      key_q      <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      hit_q      <= 1'b0;
      res_drop_q <= 1'b0;
      ins_q      <= 1'b0;
      src_q      <= '0;
      last_q     <= '0;
      wr_pend_q  <= 1'b0;
      wr_addr_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q       <= opcode_i;
            key_q      <= frame_index_i;
            lo_q       <= '0;
            hi_q       <= count_q;
            hit_q      <= 1'b0;
            res_drop_q <= 1'b0;
            state_q    <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (lo_q < hi_q) begin
            state_q <= ST_CMP;
          end else begin
            // lo_q is the lower bound; hit_q tells whether it holds the key
            wr_pend_q <= 1'b0;
            state_q   <= ST_DONE;
            if (op_q == OP_MARK && !hit_q) begin
              if (count_q < CW'(CAPACITY)) begin
                ins_q   <= 1'b1;
                count_q <= count_q + 1'b1;
                if (count_q > lo_q) begin
                  src_q   <= count_q - 1'b1;
                  last_q  <= lo_q;
                  state_q <= ST_SHIFT;
                end else begin
                  state_q <= ST_KEYWR;
                end
              end else begin
                res_drop_q <= 1'b1;
              end
            end else if (op_q == OP_UNMARK && hit_q) begin
              ins_q   <= 1'b0;
              count_q <= count_q - 1'b1;
              if (lo_q + 1'b1 < count_q) begin
                src_q   <= lo_q + 1'b1;
                last_q  <= count_q - 1'b1;
                state_q <= ST_SHIFT;
              end
            end
          end
        end
        ST_CMP: begin
          if (rd_data < key_q) begin
            lo_q <= mid + 1'b1;
          end else begin
            hi_q  <= mid;
            hit_q <= (rd_data == key_q);
          end
          state_q <= ST_SEARCH;
        end
        ST_SHIFT: begin
          // read src now, write it one slot over on the next cycle
          wr_pend_q <= 1'b1;
          wr_addr_q <= ins_q ? src_q + 1'b1 : src_q - 1'b1;
          if (src_q == last_q) begin
            state_q <= ST_FLUSH;
          end else begin
            src_q <= ins_q ? src_q - 1'b1 : src_q + 1'b1;
          end
        end
        ST_FLUSH: begin
          wr_pend_q <= 1'b0;
          state_q   <= ins_q ? ST_KEYWR : ST_DONE;
        end
        ST_KEYWR: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Output register: load when the finished beat finds the slot free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      was_present_q <= 1'b0;
      dropped_q     <= 1'b0;
      entry_count_q <= '0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q   <= 1'b1;
      was_present_q <= hit_q;
      dropped_q     <= res_drop_q;
      entry_count_q <= CNT_OUT_W'(count_q);
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  `SIS_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(CAPACITY))
  `SIS_ASSERT_IMPL(a_probe_in_range, state_q == ST_CMP, lo_q < hi_q)
  `SIS_ASSERT_IMPL(a_drop_when_full, out_valid_q && dropped_q,
                   entry_count_q == CNT_OUT_W'(CAPACITY) && !was_present_q)
  `SIS_ASSERT_NEXT(a_busy_after_beat, in_valid_i && in_ready_o, !in_ready_o)
  `SIS_ASSERT_IMPL(a_write_in_range, mem_we, waddr_c < count_q)

endmodule

FILE: rtl/core/sis_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sis_ram
// Entry store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module sis_ram
  import sis_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_CAPACITY,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [KEY_W-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [KEY_W-1:0] rdata_o
);

  logic [KEY_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for sorted_index_set. It sends query, mark and unmark beats
// and keeps its own copy of the sorted set to predict was_present, dropped
// and entry_count for each beat. A directed part covers the edge keys and
// the unused opcode. Random fill and drain phases then push the set to
// full, so that marks get refused, and back down to nearly empty. Both
// handshakes idle at random, and one long output stall backs up the input.
// ---------------------------------------------------------------------------
module tb_top;
  import sis_pkg::*;

  localparam int unsigned CAPACITY     = DEFAULT_CAPACITY;
  localparam int unsigned RANDOM_BEATS = 1850;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned FULL_BEATS   = 30;
  localparam int unsigned HOLD_CYCLES  = 600;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                 was_present;
    logic                 dropped;
    logic [CNT_OUT_W-1:0] entry_count;
  } set_result_t;

  class index_set_scoreboard;
    logic [KEY_W-1:0] held_keys [CAPACITY];
    int unsigned      held_count;
    set_result_t      expected_q [$];
    int unsigned      error_count;

    function new();
      held_count  = 0;
      error_count = 0;
    endfunction

    // First slot whose key is not below the given key.
    function int unsigned first_not_below(logic [KEY_W-1:0] key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = held_count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (held_keys[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function void note_input(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] key);
      int unsigned slot;
      logic        hit;
      set_result_t res;
      slot = first_not_below(key);
      hit  = (slot < held_count) && (held_keys[slot] == key);
      res.was_present = hit;
      res.dropped     = 1'b0;
      if (op == OP_MARK && !hit) begin
        if (held_count >= CAPACITY) begin
          res.dropped = 1'b1;
        end else begin
          for (int i = held_count; i > slot; i--) held_keys[i] = held_keys[i-1];
          held_keys[slot] = key;
          held_count++;
        end
      end else if (op == OP_UNMARK && hit) begin
        for (int i = slot; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
        held_count--;
      end
      res.entry_count = CNT_OUT_W'(held_count);
      expected_q.push_back(res);
    endfunction

    function void check_result(logic was, logic drop, logic [CNT_OUT_W-1:0] cnt);
      set_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat: was_present=%0b dropped=%0b entry_count=%0d",
                 $time, was, drop, cnt);
        error_count++;
        return;
      end
      want = expected_q.pop_front();
      if (was !== want.was_present) begin
        $display("%0t: was_present mismatch: expected %0b, actual %0b",
                 $time, want.was_present, was);
        error_count++;
      end
      if (drop !== want.dropped) begin
        $display("%0t: dropped mismatch: expected %0b, actual %0b",
                 $time, want.dropped, drop);
        error_count++;
      end
      if (cnt !== want.entry_count) begin
        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                 $time, want.entry_count, cnt);
        error_count++;
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [OPCODE_W-1:0]  opcode_i      = OP_QUERY;
  logic [KEY_W-1:0]     frame_index_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic                 was_present_o;
  logic                 dropped_o;
  logic [CNT_OUT_W-1:0] entry_count_o;

  index_set_scoreboard sb;
  bit                  calm = 1'b0;

  always #1 clk_i = ~clk_i;

  sorted_index_set #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .frame_index_i (frame_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .was_present_o (was_present_o),
    .dropped_o     (dropped_o),
    .entry_count_o (entry_count_o)
  );

  function automatic int unsigned idle_gap();
    int unsigned sel;
    sel = $urandom_range(99);
    if (calm || sel < 60) return 0;
    if (sel < 90) return $urandom_range(3, 1);
    if (sel < 98) return $urandom_range(12, 4);
    return $urandom_range(50, 20);
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_op(bit filling);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return OP_UNUSED;
    if (filling) begin
      if (sel < 85) return OP_MARK;
      if (sel < 93) return OP_QUERY;
      return OP_UNMARK;
    end
    if (sel < 70) return OP_UNMARK;
    if (sel < 85) return OP_MARK;
    return OP_QUERY;
  endfunction

  // Favor held keys and their neighbors so that hits and near misses are common.
  function automatic logic [KEY_W-1:0] pick_key(int unsigned held_pct);
    int unsigned      sel;
    logic [KEY_W-1:0] base;
    sel = $urandom_range(99);
    if (sb.held_count != 0) begin
      base = sb.held_keys[$urandom_range(sb.held_count - 1)];
      if (sel < held_pct) return base;
      if (sel < held_pct + 10) return $urandom_range(1) ? base + 32'd1 : base - 32'd1;
    end
    sel = $urandom_range(99);
    if (sel < 55) return $urandom_range(2047);
    if (sel < 65) begin
      case ($urandom_range(5))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'h7FFF_FFFF;
        3: return 32'h8000_0000;
        4: return 32'hFFFF_FFFE;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  // Offer one beat, hold it until accepted, then idle for a random gap.
  task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    frame_index_i <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(op, key);
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    bit          filling;
    int unsigned beats_at_full;
    logic [OPCODE_W-1:0] op;
    filling       = 1'b1;
    beats_at_full = 0;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(OP_QUERY,  32'h0000_0000);
    send_beat(OP_UNMARK, 32'hFFFF_FFFF);
    send_beat(OP_MARK,   32'h0000_0000);
    send_beat(OP_MARK,   32'hFFFF_FFFF);
    send_beat(OP_MARK,   32'h0000_0000);
    send_beat(OP_QUERY,  32'h0000_0000);
    send_beat(OP_QUERY,  32'hFFFF_FFFF);
    send_beat(OP_UNUSED, 32'hFFFF_FFFF);
    send_beat(OP_UNUSED, 32'h1234_5678);
    send_beat(OP_MARK,   32'h8000_0000);
    send_beat(OP_MARK,   32'h7FFF_FFFF);
    send_beat(OP_MARK,   32'h0000_0001);
    send_beat(OP_MARK,   32'hFFFF_FFFE);
    send_beat(OP_UNMARK, 32'h7FFF_FFFF);
    send_beat(OP_UNMARK, 32'h0000_0000);
    send_beat(OP_UNMARK, 32'hFFFF_FFFF);
    send_beat(OP_UNMARK, 32'h5555_5555);
    send_beat(OP_QUERY,  32'hAAAA_AAAA);
    send_beat(OP_MARK,   32'hAAAA_AAAA);
    send_beat(OP_MARK,   32'h5555_5555);

    // Alternate fill and drain phases; linger at full so marks get refused.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      calm = (n >= 200 && n < 350) || (n >= 1100 && n < 1200);
      if (sb.held_count >= CAPACITY) beats_at_full++;
      if (filling && beats_at_full >= FULL_BEATS) begin
        filling       = 1'b0;
        beats_at_full = 0;
      end else if (!filling && sb.held_count <= 8) begin
        filling = 1'b1;
      end
      op = pick_op(filling);
      send_beat(op, pick_key((op == OP_UNMARK) ? 75 : 30));
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned stall_left;
    int unsigned results_seen;
    bit          pressure_done;
    stall_left    = 0;
    results_seen  = 0;
    pressure_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result(was_present_o, dropped_o, entry_count_o);
        results_seen++;
      end
      // Hold off once for a long stretch so the input backs up.
      if (!pressure_done && results_seen >= 60) begin
        stall_left    = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (calm || $urandom_range(99) < 75) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        stall_left = ($urandom_range(99) < 5) ? $urandom_range(60, 20) : $urandom_range(3);
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/sis_pkg.sv
rtl/core/sis_ram.sv
rtl/core/sorted_index_set.sv
verif/tb_top.sv
